/* sv/stbs_pkg.sv */
package stbs_pkg;

    // Fixed field widths of the streaming and configuration ports.
    localparam int LEN_W     = 11;
    localparam int IDX_W     = 10;
    localparam int KEY_W     = 32;
    localparam int FUNC_W    = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    // Operation carried in the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_LOWER  = 2'd1,
        FUNC_UPPER  = 2'd2,
        FUNC_IGNORE = 2'd3
    } func_t;

    // One pipeline slot: the item and its search window.
    // When pend is set, the probe at position probe is still to be resolved.
    typedef struct packed {
        logic             valid;
        func_t            func;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] base;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] probe;
        logic [LEN_W-1:0] len;
        logic             pend;
    } stage_t;

    function automatic logic is_query(func_t f);
        return (f == FUNC_LOWER) || (f == FUNC_UPPER);
    endfunction

    // Apply the outcome of a pending probe to the search window.
    function automatic stage_t step_resolve(stage_t st, logic go_right);
        stage_t           r;
        logic [LEN_W-1:0] half;
        r    = st;
        half = st.count >> 1;
        if (st.pend) begin
            if (go_right) begin
                r.base  = st.probe + 1'b1;
                r.count = st.count - half - 1'b1;
            end else begin
                r.count = half;
            end
        end
        r.pend = 1'b0;
        return r;
    endfunction

endpackage

/* sv/stbs_ram.sv */
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Simple dual-port array; the read data holds while rd_en is low.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/sorted_table_bound_search.sv */
// Throughput: one transaction per cycle, except while a blocked result stalls the pipeline;
// each halving step has its own pipeline stage
// with a private copy of the table, so the rate is set by one table read per stage per cycle.
// Table writes pass down the pipeline and update each copy in order with the queries.
// Reset (aresetn low, synchronous) clears all valid bits and table_length; table
// contents are not reset and are undefined until written.
module sorted_table_bound_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stbs_pkg::S_TDATA_W-1:0]  s_tdata,  // [9:0] entry_index, [41:10] key_or_entry
    input  logic [stbs_pkg::FUNC_W-1:0]     s_tuser,  // [1:0] func
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata,  // [10:0] position
    output logic [stbs_pkg::M_TUSER_W-1:0]  m_tuser,  // [0] past_end
    // Configuration write: table_length.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stbs_pkg::LEN_W-1:0]      cfg_data
);

    import stbs_pkg::*;

    localparam int MAX_LEN = (TABLE_DEPTH < (2 ** LEN_W) - 1) ? TABLE_DEPTH : (2 ** LEN_W) - 1;
    localparam int N_STEP  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CMP_W   = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

    logic [LEN_W-1:0] table_length_reg;
    logic [LEN_W-1:0] len_sat;

    stage_t st_reg  [N_STEP+1];
    stage_t st_next [N_STEP+1];
    stage_t st_res  [N_STEP+1];
    logic   go_right [N_STEP+1];
    logic [ENTRY_WIDTH-1:0] rd_data [N_STEP];

    logic             adv;
    logic             res_valid;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [LEN_W-1:0] position_reg;
    logic             past_end_reg;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= '0;
        end else if (cfg_valid) begin
            table_length_reg <= cfg_data;
        end
    end

    assign len_sat = (table_length_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : table_length_reg;

    // The pipeline stalls only when a result is ready and the output register is blocked.
    assign res_valid = st_res[N_STEP].valid && is_query(st_res[N_STEP].func);
    assign adv       = !(m_tvalid_reg && !m_tready && res_valid);
    assign s_tready  = adv;

    // Incoming transaction opens the full search window.
    always_comb begin
        st_next[0]       = '0;
        st_next[0].valid = s_tvalid;
        st_next[0].func  = func_t'(s_tuser);
        st_next[0].idx   = s_tdata[IDX_W-1:0];
        st_next[0].key   = s_tdata[IDX_W+KEY_W-1:IDX_W];
        st_next[0].base  = '0;
        st_next[0].count = len_sat;
        st_next[0].len   = len_sat;
        st_next[0].pend  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg[0].valid <= 1'b0;
        end else if (adv) begin
            st_reg[0] <= st_next[0];
        end
    end

    generate
        for (genvar k = 0; k <= N_STEP; k++) begin : g_stage
            // Resolve the probe issued by the previous stage.
            if (k == 0) begin : g_first
                assign go_right[k] = 1'b0;
            end else begin : g_cmp
                logic signed [CMP_W-1:0] e_ext;
                logic signed [CMP_W-1:0] k_ext;
                assign e_ext = CMP_W'(signed'(rd_data[k-1]));
                assign k_ext = CMP_W'(signed'(st_reg[k].key));
                assign go_right[k] = (st_reg[k].func == FUNC_UPPER) ? !(k_ext < e_ext)
                                                                    : (e_ext < k_ext);
            end

            assign st_res[k] = step_resolve(st_reg[k], go_right[k]);

            if (k < N_STEP) begin : g_probe
                logic [LEN_W-1:0] probe;
                logic             wr_en;

                // Next probe sits in the middle of the remaining window.
                assign probe = st_res[k].base + (st_res[k].count >> 1);

                always_comb begin
                    st_next[k+1]       = st_res[k];
                    st_next[k+1].probe = probe;
                    st_next[k+1].pend  = (st_res[k].count != '0);
                end

                assign wr_en = adv && st_res[k].valid && (st_res[k].func == FUNC_WRITE)
                               && (int'(st_res[k].idx) < TABLE_DEPTH);

                // Private table copy for this step.
                stbs_ram #(
                    .WIDTH (ENTRY_WIDTH),
                    .DEPTH (TABLE_DEPTH)
                ) u_ram (
                    .clk     (aclk),
                    .wr_en   (wr_en),
                    .wr_addr (ADDR_W'(st_res[k].idx)),
                    .wr_data (ENTRY_WIDTH'(st_res[k].key)),
                    .rd_en   (adv),
                    .rd_addr (ADDR_W'(probe)),
                    .rd_data (rd_data[k])
                );

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        st_reg[k+1].valid <= 1'b0;
                    end else if (adv) begin
                        st_reg[k+1] <= st_next[k+1];
                    end
                end
            end
        end
    endgenerate

    // Output register: load a finished query, or drain once the result is taken.
    always_comb begin
        if (adv && res_valid) begin
            m_tvalid_next = 1'b1;
        end else begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res_valid) begin
            position_reg <= st_res[N_STEP].base;
            past_end_reg <= (st_res[N_STEP].base == st_res[N_STEP].len);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(position_reg);
    assign m_tuser  = past_end_reg;

endmodule

/* sv/stbs_checker.sv */
module stbs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [stbs_pkg::FUNC_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [stbs_pkg::M_TUSER_W-1:0]  m_tuser
);

    import stbs_pkg::*;

    logic [15:0] pending_reg;
    logic [15:0] pending_next;
    logic        query_in;
    logic        result_out;

    // Count queries accepted but not yet delivered.
    assign query_in   = s_tvalid && s_tready
                        && ((s_tuser == FUNC_LOWER) || (s_tuser == FUNC_UPPER));
    assign result_out = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg + {15'd0, query_in} - {15'd0, result_out};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Every result answers a query that was accepted earlier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != '0)
        else $error("result without an outstanding query");

endmodule

bind sorted_table_bound_search stbs_checker u_stbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/sv/tb_sorted_table_bound_search.sv */
module tb_sorted_table_bound_search;
    import stbs_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_COUNT    = 14;
    localparam int PHASE_ITEMS    = 44;
    localparam int PRESSURE_PHASE = 4;
    localparam int PAUSE_PHASE    = 9;
    localparam int FILL_LIMIT     = 256;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    // Table lengths used by the random phases, extremes and saturating values included.
    localparam int PHASE_LEN [PHASE_COUNT] = '{
        1, 2, 3, 16, 100, 1024, 2047, 0, 5, 1025, 255, 1024, 40, 2047
    };

    // One search result: first qualifying position and the past-end flag.
    typedef struct packed {
        logic [LEN_W-1:0] position;
        logic             past_end;
    } bound_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_LENGTH
    } row_kind_t;

    // A directed row is either a stream item or a table_length write (value in data).
    typedef struct packed {
        row_kind_t        kind;
        func_t            func;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] data;
        logic             typed;
        logic [LEN_W-1:0] pos;
        logic             past;
    } dir_row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PERIODIC
    } ready_mode_t;

    localparam int DIR_ROWS = 25;

    // Empty table after reset, a small sorted table with duplicates, an out-of-order
    // entry, ignored items, and keys at both ends of the signed range.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_ITEM,   FUNC_LOWER,  10'd0,   KEY_MIN,       1'b1, 11'd0, 1'b1},
        '{ROW_ITEM,   FUNC_UPPER,  10'h3FF, KEY_MAX,       1'b1, 11'd0, 1'b1},
        '{ROW_ITEM,   FUNC_IGNORE, 10'h3FF, 32'hFFFF_FFFF, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd0,   KEY_MIN,       1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd1,   32'hFFFF_FFFB, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd2,   32'hFFFF_FFFB, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd3,   32'd0,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd4,   32'd0,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd5,   32'd0,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd6,   32'd1000,      1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd7,   KEY_MAX,       1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'h3FF, KEY_MAX,       1'b0, 11'd0, 1'b0},
        '{ROW_LENGTH, FUNC_WRITE,  10'd0,   32'd8,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_LOWER,  10'd0,   KEY_MIN,       1'b1, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_UPPER,  10'd0,   KEY_MIN,       1'b1, 11'd1, 1'b0},
        '{ROW_ITEM,   FUNC_LOWER,  10'd0,   KEY_MAX,       1'b1, 11'd7, 1'b0},
        '{ROW_ITEM,   FUNC_UPPER,  10'd0,   KEY_MAX,       1'b1, 11'd8, 1'b1},
        '{ROW_ITEM,   FUNC_LOWER,  10'd0,   32'd0,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_UPPER,  10'd0,   32'd0,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_UPPER,  10'h3FF, 32'hFFFF_FFFA, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd3,   32'h7FFF_FFF0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_LOWER,  10'd0,   32'd1000,      1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_IGNORE, 10'd0,   32'd0,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_WRITE,  10'd3,   32'd0,         1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   FUNC_UPPER,  10'd0,   32'hFFFF_FFFB, 1'b0, 11'd0, 1'b0}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [FUNC_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LEN_W-1:0]     cfg_data  = '0;

    // Shadow of the block: table contents, which entries hold data, and table_length.
    logic signed [KEY_W-1:0] shadow_entries [DEPTH];
    bit                      written [DEPTH];
    bit                      dirty [DEPTH];
    longint                  base_val [DEPTH];
    logic [LEN_W-1:0]        length_reg = '0;

    bound_t expected_bounds [$];
    int     mismatches = 0;
    int     burst_left = 0;
    bit     hold_req   = 1'b0;

    sorted_table_bound_search #(
        .TABLE_DEPTH(DEPTH),
        .ENTRY_WIDTH(KEY_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Halving search over the shadow table with the saturated length.
    function automatic bound_t predict_bound(input logic signed [KEY_W-1:0] key,
                                             input logic upper);
        int unsigned eff, lo, span, half, probe;
        logic        go_right;
        bound_t      r;
        eff  = (int'(length_reg) > DEPTH) ? DEPTH : int'(length_reg);
        lo   = 0;
        span = eff;
        while (span > 0) begin
            half     = span / 2;
            probe    = lo + half;
            go_right = upper ? !(key < shadow_entries[probe]) : (shadow_entries[probe] < key);
            if (go_right) begin
                lo   = probe + 1;
                span = span - half - 1;
            end else begin
                span = half;
            end
        end
        r.position = LEN_W'(lo);
        r.past_end = (lo == eff);
        return r;
    endfunction

    // Offer one item and update the shadow once the transaction completes.
    task automatic offer(input func_t f, input logic [IDX_W-1:0] idx,
                         input logic [KEY_W-1:0] data, input logic typed,
                         input bound_t typed_res);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - KEY_W - IDX_W){1'b0}}, data, idx};
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (f)
            FUNC_WRITE: begin
                shadow_entries[idx] = data;
                written[idx]        = 1'b1;
            end
            FUNC_LOWER, FUNC_UPPER: begin
                expected_bounds.push_back(typed ? typed_res : predict_bound(data, f == FUNC_UPPER));
            end
            default: ;
        endcase
    endtask

    // Sender runs in bursts; a new burst may start after a gap.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1, 2, 7: gap = 0;
                3, 4, 5:    gap = $urandom_range(1, 4);
                default:    gap = $urandom_range(5, 20);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // Stop sending, wait for every pending result, then let trailing writes settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_bounds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_table_length(input logic [LEN_W-1:0] len);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        length_reg = len;
    endtask

    // Result side: check each transaction and drive tready on a changing pattern.
    initial begin : result_sink
        ready_mode_t mode;
        int          seg_left;
        int          hold_left;
        bound_t      want;
        mode      = RDY_ALWAYS;
        seg_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_bounds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: tdata %h tuser %h", m_tdata, m_tuser);
                end else begin
                    want = expected_bounds.pop_front();
                    if (m_tdata !== M_TDATA_W'(want.position)
                        || m_tuser[0] !== want.past_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("bound mismatch: expected position %0d past_end %0d,",
                                     want.position, want.past_end,
                                     " got tdata %h tuser %h", m_tdata, m_tuser);
                    end
                end
            end
            // A requested hold-off keeps tready low for a long counted stretch.
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = ready_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                case (mode)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_tready <= (seg_left % 5 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int               eff;
        int               roll;
        int               idx;
        int               p_lo;
        int               p_span;
        int               p_half;
        bit               wide;
        func_t            f;
        logic [KEY_W-1:0] key;
        longint           lo;
        longint           hi;
        logic [63:0]      span;
        logic [63:0]      rnd64;

        // Ascending baseline over the whole signed range, with runs of equal entries.
        base_val[0] = longint'($signed(KEY_MIN));
        for (int i = 1; i < DEPTH - 1; i++) begin
            base_val[i] = base_val[i-1] +
                          (($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 8000000));
            if (base_val[i] > longint'($signed(KEY_MAX)))
                base_val[i] = longint'($signed(KEY_MAX));
        end
        base_val[DEPTH-1] = longint'($signed(KEY_MAX));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_LENGTH) begin
                set_table_length(DIRECTED[r].data[LEN_W-1:0]);
            end else begin
                pace();
                offer(DIRECTED[r].func, DIRECTED[r].idx, DIRECTED[r].data, DIRECTED[r].typed,
                      bound_t'{DIRECTED[r].pos, DIRECTED[r].past});
            end
        end

        // Entries written by the directed rows do not follow the baseline.
        for (int i = 0; i < DEPTH; i++)
            dirty[i] = written[i];

        // Random phases, one table length each.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_table_length(LEN_W'(PHASE_LEN[p]));
            eff  = (PHASE_LEN[p] > DEPTH) ? DEPTH : PHASE_LEN[p];
            wide = (eff > FILL_LIMIT);

            if (wide) begin
                // Wide tables load only the entries on the all-left and all-right paths.
                for (int side = 0; side < 2; side++) begin
                    p_lo   = 0;
                    p_span = eff;
                    while (p_span > 0) begin
                        p_half = p_span / 2;
                        idx    = p_lo + p_half;
                        if (!written[idx] || dirty[idx]) begin
                            pace();
                            offer(FUNC_WRITE, IDX_W'(idx), KEY_W'(base_val[idx]), 1'b0, '0);
                            dirty[idx] = 1'b0;
                        end
                        if (side == 1) begin
                            p_lo   = idx + 1;
                            p_span = p_span - p_half - 1;
                        end else begin
                            p_span = p_half;
                        end
                    end
                end
            end else begin
                // Every entry a search can reach gets data in baseline order first.
                for (int i = 0; i < eff; i++) begin
                    if (!written[i] || dirty[i]) begin
                        pace();
                        offer(FUNC_WRITE, IDX_W'(i), KEY_W'(base_val[i]), 1'b0, '0);
                        dirty[i] = 1'b0;
                    end
                end
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == PRESSURE_PHASE && k == 20)
                    hold_req = 1'b1;
                if (p == PAUSE_PHASE && k == 30)
                    drain_results();
                pace();
                roll = $urandom_range(0, 99);
                idx  = (eff > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, eff - 1)
                                                               : $urandom_range(0, DEPTH - 1);
                if (roll < 55) begin
                    // Query: keys at the range ends, fully random, or next to a stored entry.
                    f = (roll < 27) ? FUNC_LOWER : FUNC_UPPER;
                    if (wide) begin
                        // These keys keep the search on the loaded edge paths.
                        key = (f == FUNC_LOWER) ? KEY_MIN : KEY_MAX;
                    end else begin
                        case ($urandom_range(0, 3))
                            0: begin
                                case ($urandom_range(0, 3))
                                    0:       key = KEY_MIN;
                                    1:       key = KEY_MIN + 1'b1;
                                    2:       key = KEY_MAX - 1'b1;
                                    default: key = KEY_MAX;
                                endcase
                            end
                            1: key = $urandom();
                            default: begin
                                if (eff > 0)
                                    key = shadow_entries[$urandom_range(0, eff - 1)] +
                                          KEY_W'(int'($urandom_range(0, 2)) - 1);
                                else
                                    key = $urandom();
                            end
                        endcase
                    end
                    offer(f, IDX_W'($urandom()), key, 1'b0, '0);
                end else if (roll < 85) begin
                    // Write that keeps the table sorted: a value between its neighbors.
                    lo    = (idx == 0) ? longint'($signed(KEY_MIN)) : base_val[idx-1];
                    hi    = (idx == DEPTH - 1) ? longint'($signed(KEY_MAX)) : base_val[idx+1];
                    span  = 64'(hi - lo) + 64'd1;
                    rnd64 = {$urandom(), $urandom()};
                    base_val[idx] = lo + longint'(rnd64 % span);
                    offer(FUNC_WRITE, IDX_W'(idx), KEY_W'(base_val[idx]), 1'b0, '0);
                    dirty[idx] = 1'b0;
                end else if (roll < 95) begin
                    // Write of arbitrary data, which may break the ordering.
                    offer(FUNC_WRITE, IDX_W'(idx), $urandom(), 1'b0, '0);
                    dirty[idx] = 1'b1;
                end else begin
                    offer(FUNC_IGNORE, IDX_W'($urandom()), $urandom(), 1'b0, '0);
                end
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sorted_table_bound_search.f */
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/sorted_table_bound_search.sv
sv/stbs_checker.sv
tb/sv/tb_sorted_table_bound_search.sv
